[src/two_stack_queue_macros.svh]
// ----------------------------------------------------------------------------
// two_stack_queue assertion macros
// Shared concurrent assertion shorthands, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_STACK_QUEUE_MACROS_SVH
`define TWO_STACK_QUEUE_MACROS_SVH

// same-cycle implication
`define TSQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tsq_pkg.sv]
// ----------------------------------------------------------------------------
// tsq_pkg
// Sizes, codes and shared types of the two-stack queue.
// ----------------------------------------------------------------------------
package tsq_pkg;

  localparam int DEPTH  = 128;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OCC_W  = 9;
  localparam int SUM_W  = (CNT_W + 1 > OCC_W) ? CNT_W + 1 : OCC_W;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              in_we;
    logic [ADDR_W-1:0] in_waddr;
    logic              in_re;
    logic [ADDR_W-1:0] in_raddr;
    logic              out_we;
    logic [ADDR_W-1:0] out_waddr;
    logic              out_re;
    logic [ADDR_W-1:0] out_raddr;
  } mem_req_t;

  function automatic logic [OCC_W-1:0] occ_sum(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return s[OCC_W-1:0];
  endfunction

endpackage

[src/tsq_ctrl.sv]
// ----------------------------------------------------------------------------
// tsq_ctrl
// Stack pointers, request sequencing and result beat of the two-stack queue.
// ----------------------------------------------------------------------------
`include "two_stack_queue_macros.svh"

module tsq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [tsq_pkg::DATA_W-1:0]  ib_rdata,
  input  logic [tsq_pkg::DATA_W-1:0]  ob_rdata,
  output tsq_pkg::mem_req_t           mem,
  output logic                        out_valid,
  output logic [tsq_pkg::DATA_W-1:0]  out_value,
  output logic [1:0]                  out_status,
  output logic [tsq_pkg::OCC_W-1:0]   out_occupancy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_XFER = 2'd2;
  localparam logic [1:0] S_LAST = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [tsq_pkg::CNT_W-1:0]  in_cnt_r, in_cnt_nxt;
  logic [tsq_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                       res_vld_r, res_vld_nxt;
  logic [tsq_pkg::DATA_W-1:0] res_val_r, res_val_nxt;
  logic [1:0]                 res_st_r, res_st_nxt;
  logic [tsq_pkg::OCC_W-1:0]  res_occ_r, res_occ_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    mem         = '0;
    res_vld_nxt = 1'b0;
    res_val_nxt = '0;
    res_st_nxt  = tsq_pkg::ST_OK;
    res_occ_nxt = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_req_type == tsq_pkg::REQ_ENQ) begin
            res_vld_nxt = 1'b1;
            if (in_cnt_r == tsq_pkg::CNT_W'(tsq_pkg::DEPTH)) begin
              res_st_nxt  = tsq_pkg::ST_FULL;
              res_occ_nxt = tsq_pkg::occ_sum(in_cnt_r, out_cnt_r);
            end else begin
              mem.in_we    = 1'b1;
              mem.in_waddr = in_cnt_r[tsq_pkg::ADDR_W-1:0];
              in_cnt_nxt   = in_cnt_r + 1'b1;
              res_occ_nxt  = tsq_pkg::occ_sum(in_cnt_nxt, out_cnt_r);
            end
          end else if (out_cnt_r != '0) begin
            out_cnt_nxt   = out_cnt_r - 1'b1;
            mem.out_re    = 1'b1;
            mem.out_raddr = out_cnt_nxt[tsq_pkg::ADDR_W-1:0];
            state_nxt     = S_DEQ;
          end else if (in_cnt_r != '0) begin
            in_cnt_nxt   = in_cnt_r - 1'b1;
            mem.in_re    = 1'b1;
            mem.in_raddr = in_cnt_nxt[tsq_pkg::ADDR_W-1:0];
            state_nxt    = (in_cnt_nxt == '0) ? S_LAST : S_XFER;
          end else begin
            res_vld_nxt = 1'b1;
            res_st_nxt  = tsq_pkg::ST_EMPTY;
            res_occ_nxt = tsq_pkg::occ_sum(in_cnt_r, out_cnt_r);
          end
        end
      end
      S_DEQ: begin
        res_vld_nxt = 1'b1;
        res_val_nxt = ob_rdata;
        res_occ_nxt = tsq_pkg::occ_sum(in_cnt_r, out_cnt_r);
        state_nxt   = S_IDLE;
      end
      S_XFER: begin
        // push the element read last cycle, pop the next one
        mem.out_we    = 1'b1;
        mem.out_waddr = out_cnt_r[tsq_pkg::ADDR_W-1:0];
        out_cnt_nxt   = out_cnt_r + 1'b1;
        in_cnt_nxt    = in_cnt_r - 1'b1;
        mem.in_re     = 1'b1;
        mem.in_raddr  = in_cnt_nxt[tsq_pkg::ADDR_W-1:0];
        if (in_cnt_nxt == '0) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        // oldest element goes straight out, never lands in the outbound stack
        res_vld_nxt = 1'b1;
        res_val_nxt = ib_rdata;
        res_occ_nxt = tsq_pkg::occ_sum(in_cnt_r, out_cnt_r);
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    res_occ_r <= res_occ_nxt;
  end

  assign out_valid     = res_vld_r;
  assign out_value     = res_val_r;
  assign out_status    = res_st_r;
  assign out_occupancy = res_occ_r;

  `TSQ_ASSERT_IMP(a_cnt_bound, 1'b1, (in_cnt_r <= tsq_pkg::CNT_W'(tsq_pkg::DEPTH)) && (out_cnt_r <= tsq_pkg::CNT_W'(tsq_pkg::DEPTH)), "stack count past depth")
  `TSQ_ASSERT_IMP(a_port_excl, 1'b1, !(mem.in_we && mem.in_re) && !(mem.out_we && mem.out_re), "read and write on one memory in one cycle")
  `TSQ_ASSERT_NXT(a_beat_follows, start && !busy, res_vld_r || busy, "accepted request produced neither beat nor work")
  `TSQ_ASSERT_NXT(a_last_beat, state_r == S_LAST, res_vld_r && !busy, "transfer end gave no beat")
  `TSQ_ASSERT_IMP(a_empty_beat, res_vld_r && (res_st_r == tsq_pkg::ST_EMPTY), (res_val_r == '0) && (res_occ_r == '0), "empty beat carries data")

endmodule

[src/two_stack_queue.sv]
// ----------------------------------------------------------------------------
// two_stack_queue
// FIFO queue of signed 32-bit words built from an inbound and outbound stack.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_req_type and in_value_in; the request is taken at a
//   clock edge where start is high and busy is low. in_req_type 0 pushes
//   in_value_in, 1 pops the oldest element.
//   Every request yields one result beat: out_valid high for one cycle with
//   out_value_out, out_status (ok, full-and-dropped, empty) and
//   out_occupancy. The receiver cannot stall; each beat must be taken.
//   Sequencing and throughput:
//     enqueue, full or empty request: beat in the cycle after accept, busy stays
//     low, so one request per cycle.
//     dequeue with outbound elements: beat from S_DEQ on registered read data.
//     dequeue with empty outbound stack and N inbound elements: beat from
//     S_LAST after the transfer; the transfer moves one element per cycle, bound
//     by the single read port of the inbound memory.
//   Reset empties both stacks and drops any pending beat; memory contents
//   are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module two_stack_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic signed [tsq_pkg::DATA_W-1:0]  in_value_in,
  output logic                               out_valid,
  output logic signed [tsq_pkg::DATA_W-1:0]  out_value_out,
  output logic [1:0]                         out_status,
  output logic [tsq_pkg::OCC_W-1:0]          out_occupancy
);

  logic [tsq_pkg::DATA_W-1:0] ib_mem [tsq_pkg::DEPTH];
  logic [tsq_pkg::DATA_W-1:0] ob_mem [tsq_pkg::DEPTH];
  logic [tsq_pkg::DATA_W-1:0] ib_rdata_r;
  logic [tsq_pkg::DATA_W-1:0] ob_rdata_r;
  logic [tsq_pkg::DATA_W-1:0] res_value;
  tsq_pkg::mem_req_t          mem;

  always_ff @(posedge clk) begin
    if (mem.in_we) begin
      ib_mem[mem.in_waddr] <= in_value_in;
    end
    if (mem.in_re) begin
      ib_rdata_r <= ib_mem[mem.in_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem.out_we) begin
      ob_mem[mem.out_waddr] <= ib_rdata_r;
    end
    if (mem.out_re) begin
      ob_rdata_r <= ob_mem[mem.out_raddr];
    end
  end

  tsq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .ib_rdata      (ib_rdata_r),
    .ob_rdata      (ob_rdata_r),
    .mem           (mem),
    .out_valid     (out_valid),
    .out_value     (res_value),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  assign out_value_out = res_value;

endmodule
